// ----- hdl/pgd_pkg.sv -----
// ----------------------------------------------------------------------------
// pgd_pkg
// Shared types and constants of the pen plotter grid drawer.
// ----------------------------------------------------------------------------
package pgd_pkg;

  // Grid geometry
  localparam int GridSize = 64;
  localparam int CoordW   = 6;
  localparam int Cells    = GridSize * GridSize;
  localparam int AddrW    = $clog2(Cells);
  localparam int DistW    = 6;
  localparam int WideW    = 9;

  // Operation codes
  localparam logic OpPen  = 1'b0;
  localparam logic OpRead = 1'b1;

  // Heading codes
  localparam logic [1:0] HeadNorth = 2'd0;
  localparam logic [1:0] HeadEast  = 2'd1;
  localparam logic [1:0] HeadSouth = 2'd2;
  localparam logic [1:0] HeadWest  = 2'd3;

  // Cell codes
  localparam logic [1:0] CellBlank = 2'd0;
  localparam logic [1:0] CellStar  = 2'd1;
  localparam logic [1:0] CellHash  = 2'd2;

  // Result status codes
  localparam logic [1:0] StatDone    = 2'd0;
  localparam logic [1:0] StatOut     = 2'd1;
  localparam logic [1:0] StatInvalid = 2'd2;

  typedef enum logic [2:0] {
    StClear,
    StIdle,
    StDraw,
    StRead,
    StDone
  } pgd_state_e;

endpackage

// ----- hdl/pgd_cmd_if.sv -----
// ----------------------------------------------------------------------------
// pgd_cmd_if
// Command channel: valid/ready handshake with one command or read item.
// ----------------------------------------------------------------------------
interface pgd_cmd_if;
  import pgd_pkg::*;

  logic              valid;
  logic              ready;
  logic              operation;
  logic              pen_down;
  logic [1:0]        heading;
  logic [DistW-1:0]  step_count;
  logic              heavy_stroke;
  logic [CoordW-1:0] read_row;
  logic [CoordW-1:0] read_col;

  modport source (
    output valid, operation, pen_down, heading, step_count, heavy_stroke,
           read_row, read_col,
    input  ready
  );

  modport sink (
    input  valid, operation, pen_down, heading, step_count, heavy_stroke,
           read_row, read_col,
    output ready
  );

endinterface

// ----- hdl/pgd_res_if.sv -----
// ----------------------------------------------------------------------------
// pgd_res_if
// Result channel: valid/ready handshake with one result item.
// ----------------------------------------------------------------------------
interface pgd_res_if;
  import pgd_pkg::*;

  logic              valid;
  logic              ready;
  logic [1:0]        result_status;
  logic [CoordW-1:0] pen_row_out;
  logic [CoordW-1:0] pen_col_out;
  logic [1:0]        cell_value;

  modport source (
    output valid, result_status, pen_row_out, pen_col_out, cell_value,
    input  ready
  );

  modport sink (
    input  valid, result_status, pen_row_out, pen_col_out, cell_value,
    output ready
  );

endinterface

// ----- hdl/pen_plotter_grid_drawer_core.sv -----
// ----------------------------------------------------------------------------
// pen_plotter_grid_drawer_core
// Pen plotter on a square character grid held in one frame memory.
// ----------------------------------------------------------------------------
// The block keeps a pen position, starting at the top-left cell, and a frame
// of blank, star and hash cells in a single memory with one write and one
// read port and a registered read. After reset a clearing pass writes blank
// to every cell of the 64 x 64 grid, one per cycle; no item is accepted
// during it. Items are handled one at a time. A read item passes through the
// read state, where the memory output is captured, and then the done state;
// an invalid command, a command that would leave the grid, or a move with the
// pen up goes straight to the done state. In a drawing command the memory
// reads one cell along the run per cycle, and the cell read in the previous
// cycle is written back in the same cycle, so a star can be held off a hash;
// a final pass through the draw state writes back the last cell of the run.
// A new item is taken once the previous result sits in the output register,
// even while that result still waits to be taken.
// ----------------------------------------------------------------------------
module pen_plotter_grid_drawer_core (
  input  logic     clk_i,
  input  logic     rst_ni,
  pgd_cmd_if.sink   cmd_i,
  pgd_res_if.source res_o
);
  import pgd_pkg::*;

  // Frame memory
  logic [1:0] frame_mem [Cells];
  logic [1:0] rd_data_q;
  logic             rd_en;
  logic [AddrW-1:0] rd_addr;
  logic             wr_en;
  logic [AddrW-1:0] wr_addr;
  logic [1:0]       wr_data;

  // Control and datapath registers
  pgd_state_e state_q, state_d;
  logic [AddrW-1:0]  clr_q, clr_d;
  logic [CoordW-1:0] pen_row_q, pen_row_d, pen_col_q, pen_col_d;
  logic [CoordW-1:0] cur_row_q, cur_row_d, cur_col_q, cur_col_d;
  logic [DistW-1:0]  cnt_q, cnt_d;
  logic [1:0]        head_q, head_d;
  logic [1:0]        ink_q, ink_d;
  logic              pend_q, pend_d;
  logic [AddrW-1:0]  pend_addr_q, pend_addr_d;
  logic [1:0]        res_status_q, res_status_d;
  logic [1:0]        res_cell_q, res_cell_d;
  logic              out_valid_q, out_valid_d;
  logic [1:0]        out_status_q, out_status_d;
  logic [CoordW-1:0] out_row_q, out_row_d, out_col_q, out_col_d;
  logic [1:0]        out_cell_q, out_cell_d;

  // Decode of the offered item
  logic              is_read;
  logic              read_in_grid;
  logic              cmd_bad;
  logic              cmd_leaves;
  logic [CoordW-1:0] end_row, end_col;
  logic [CoordW-1:0] step_row, step_col;
  logic              out_free;
  logic [WideW-1:0]  row_w, col_w, dist_w, last_w;

  function automatic logic [AddrW-1:0] cell_addr(logic [CoordW-1:0] row,
                                                 logic [CoordW-1:0] col);
    cell_addr = AddrW'(row) * AddrW'(GridSize) + AddrW'(col);
  endfunction

  assign out_free = !out_valid_q || res_o.ready;

  always_comb begin
    row_w   = WideW'(pen_row_q);
    col_w   = WideW'(pen_col_q);
    dist_w  = WideW'(cmd_i.step_count);
    last_w  = WideW'(GridSize - 1);
    is_read = (cmd_i.operation == OpRead);
    read_in_grid = (WideW'(cmd_i.read_row) <= last_w) &&
                   (WideW'(cmd_i.read_col) <= last_w);
    cmd_bad = (cmd_i.step_count == '0) || (cmd_i.heavy_stroke && !cmd_i.pen_down);
    end_row = pen_row_q;
    end_col = pen_col_q;
    cmd_leaves = 1'b0;
    case (cmd_i.heading)
      HeadNorth: begin
        cmd_leaves = dist_w > row_w;
        end_row    = pen_row_q - cmd_i.step_count;
      end
      HeadEast: begin
        cmd_leaves = (col_w + dist_w) > last_w;
        end_col    = pen_col_q + cmd_i.step_count;
      end
      HeadSouth: begin
        cmd_leaves = (row_w + dist_w) > last_w;
        end_row    = pen_row_q + cmd_i.step_count;
      end
      default: begin
        cmd_leaves = dist_w > col_w;
        end_col    = pen_col_q - cmd_i.step_count;
      end
    endcase
  end

  // Next cell along the current run
  always_comb begin
    step_row = cur_row_q;
    step_col = cur_col_q;
    case (head_q)
      HeadNorth: step_row = cur_row_q - 1'b1;
      HeadEast:  step_col = cur_col_q + 1'b1;
      HeadSouth: step_row = cur_row_q + 1'b1;
      default:   step_col = cur_col_q - 1'b1;
    endcase
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StClear: if (clr_q == AddrW'(Cells - 1)) state_d = StIdle;
      StIdle: begin
        if (cmd_i.valid) begin
          if (is_read) begin
            state_d = read_in_grid ? StRead : StDone;
          end else if (!cmd_bad && !cmd_leaves && cmd_i.pen_down) begin
            state_d = StDraw;
          end else begin
            state_d = StDone;
          end
        end
      end
      StDraw: if (cnt_q == '0) state_d = StDone;
      StRead: state_d = StDone;
      StDone: if (out_free) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // Outputs and datapath
  always_comb begin
    cmd_i.ready  = (state_q == StIdle);
    rd_en        = 1'b0;
    rd_addr      = '0;
    wr_en        = 1'b0;
    wr_addr      = '0;
    wr_data      = CellBlank;
    clr_d        = clr_q;
    pen_row_d    = pen_row_q;
    pen_col_d    = pen_col_q;
    cur_row_d    = cur_row_q;
    cur_col_d    = cur_col_q;
    cnt_d        = cnt_q;
    head_d       = head_q;
    ink_d        = ink_q;
    pend_d       = 1'b0;
    pend_addr_d  = pend_addr_q;
    res_status_d = res_status_q;
    res_cell_d   = res_cell_q;
    out_valid_d  = out_valid_q && !res_o.ready;
    out_status_d = out_status_q;
    out_row_d    = out_row_q;
    out_col_d    = out_col_q;
    out_cell_d   = out_cell_q;

    unique case (state_q)
      StClear: begin
        // Blank one cell per cycle
        wr_en = 1'b1;
        wr_addr = clr_q;
        clr_d = clr_q + 1'b1;
      end
      StIdle: begin
        if (cmd_i.valid) begin
          res_cell_d = CellBlank;
          if (is_read) begin
            if (read_in_grid) begin
              rd_en        = 1'b1;
              rd_addr      = cell_addr(cmd_i.read_row, cmd_i.read_col);
              res_status_d = StatDone;
            end else begin
              res_status_d = StatOut;
            end
          end else if (cmd_bad) begin
            res_status_d = StatInvalid;
          end else if (cmd_leaves) begin
            res_status_d = StatOut;
          end else begin
            // Commit the end position now; the run walks from the old one
            res_status_d = StatDone;
            pen_row_d    = end_row;
            pen_col_d    = end_col;
            cur_row_d    = pen_row_q;
            cur_col_d    = pen_col_q;
            cnt_d        = cmd_i.step_count;
            head_d       = cmd_i.heading;
            ink_d        = cmd_i.heavy_stroke ? CellHash : CellStar;
          end
        end
      end
      StDraw: begin
        // Read the next cell of the run
        if (cnt_q != '0) begin
          rd_en       = 1'b1;
          rd_addr     = cell_addr(step_row, step_col);
          cur_row_d   = step_row;
          cur_col_d   = step_col;
          cnt_d       = cnt_q - 1'b1;
          pend_d      = 1'b1;
          pend_addr_d = rd_addr;
        end
        // Write back the cell read last cycle; a star leaves a hash alone
        if (pend_q) begin
          wr_en   = !(ink_q == CellStar && rd_data_q == CellHash);
          wr_addr = pend_addr_q;
          wr_data = ink_q;
        end
      end
      StRead: res_cell_d = rd_data_q;
      StDone: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_row_d    = pen_row_q;
          out_col_d    = pen_col_q;
          out_cell_d   = res_cell_q;
        end
      end
      default: ;
    endcase
  end

  assign res_o.valid         = out_valid_q;
  assign res_o.result_status = out_status_q;
  assign res_o.pen_row_out   = out_row_q;
  assign res_o.pen_col_out   = out_col_q;
  assign res_o.cell_value    = out_cell_q;

  // Frame memory ports
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      frame_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= frame_mem[rd_addr];
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      clr_q       <= '0;
      pen_row_q   <= '0;
      pen_col_q   <= '0;
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      pen_row_q   <= pen_row_d;
      pen_col_q   <= pen_col_d;
      cnt_q       <= cnt_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cur_row_q    <= cur_row_d;
    cur_col_q    <= cur_col_d;
    head_q       <= head_d;
    ink_q        <= ink_d;
    pend_addr_q  <= pend_addr_d;
    res_status_q <= res_status_d;
    res_cell_q   <= res_cell_d;
    out_status_q <= out_status_d;
    out_row_q    <= out_row_d;
    out_col_q    <= out_col_d;
    out_cell_q   <= out_cell_d;
  end

endmodule
